>>> hw/rtl/gif_lzw_decoder_macros.svh
// assertion macros for the gif lzw decoder
// used by the top level only; no other dependencies
`ifndef GIF_LZW_DECODER_MACROS_SVH
`define GIF_LZW_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("gld check failed");
`define GLD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("gld check failed");
`else
`define GLD_ASSERT_NOW(lbl, clk, rst_n, a, c)
`define GLD_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/gld_pkg.sv
// shared types, codes and helpers of the gif lzw decoder
// no dependencies
package gld_pkg;

  localparam int CODE_W = 12;
  localparam int NFE_W  = 13;
  localparam int OUT_DATA_W = 72;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [2:0] ST_PIXEL   = 3'd0;
  localparam logic [2:0] ST_TAKEN   = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;
  localparam logic [2:0] ST_STARTED = 3'd6;

  localparam logic [2:0] IDX_INIT_SIZE = 3'd0;
  localparam logic [2:0] IDX_WIDTH     = 3'd1;
  localparam logic [2:0] IDX_HEIGHT    = 3'd2;
  localparam logic [2:0] IDX_STRIDE    = 3'd3;
  localparam logic [2:0] IDX_INTERLACE = 3'd4;

  typedef struct packed {
    logic [3:0]  init_code_size;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [16:0] row_stride;
    logic        interlace_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  function automatic logic [3:0] min_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [15:0] next_row(input logic [15:0] r, input logic [15:0] h,
                                           input logic il);
    logic [16:0] r8, r4;
    logic [15:0] n;
    r8 = {1'b0, r} + 17'd8;
    r4 = {1'b0, r} + 17'd4;
    if (!il) begin
      n = r + 16'd1;
    end else if (r[2:0] == 3'd0) begin
      if (r8 < {1'b0, h}) n = r8[15:0];
      else if (h > 16'd4) n = 16'd4;
      else if (h > 16'd2) n = 16'd2;
      else n = 16'd1;
    end else if (r[1:0] == 2'd0) begin
      if (r8 < {1'b0, h}) n = r8[15:0];
      else if (h > 16'd2) n = 16'd2;
      else n = 16'd1;
    end else if (r[0] == 1'b0) begin
      if (r4 < {1'b0, h}) n = r4[15:0];
      else n = 16'd1;
    end else begin
      n = r + 16'd2;
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/gld_ram.sv
// generic single write port ram with registered read
// no dependencies
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gld_front.sv
// input side: takes beats, drops unknown operations, queues the rest
// depends on gld_pkg
module gld_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_tuser,
  input  logic [7:0]       in_tdata,
  output gld_pkg::q_head_t head,
  input  logic             pop
);
  import gld_pkg::*;

  q_item_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       known;

  assign in_tready  = (cnt_r != 2'd2);
  assign known      = (in_tuser == OP_START) || (in_tuser == OP_PUSH) || (in_tuser == OP_PULL);
  assign push       = in_tvalid && in_tready && known;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= '{op: in_tuser, data_byte: in_tdata};
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> hw/rtl/gld_core.sv
// back end: lzw code extraction, table walk, expansion stack, pixel placement
// depends on gld_pkg and gld_ram
module gld_core #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gld_pkg::cfg_t                       cfg,
  input  gld_pkg::q_head_t                    head,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2:0]                          out_tuser,
  output logic [gld_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);
  import gld_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_PULL, S_WALK, S_WDAT, S_PIX, S_ERR} state_t;
  typedef enum logic [1:0] {PH_RUN, PH_DONE, PH_ERR} phase_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [AW:0]       stk_r, stk_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [4:0]        held_r, held_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [NFE_W-1:0]  nfe_r, nfe_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt, code_r, code_nxt, walk_r, walk_nxt;
  logic [7:0]        pfs_r, pfs_nxt;
  logic [15:0]       row_r, row_nxt, col_r, col_nxt;
  logic [31:0]       pix_r, pix_nxt, maxpix_r, prod_r, prod_nxt;
  logic              o_valid_r, o_valid_nxt, o_last_r, o_last_nxt;
  logic [2:0]        o_status_r, o_status_nxt;
  logic [OUT_DATA_W-1:0] o_data_r, o_data_nxt;

  logic [3:0]        ms;
  logic [CODE_W-1:0] clr, eoi, first, code;
  logic [23:0]       mask;
  logic              slot_free, stk_full;
  logic [31:0]       pix_inc;
  logic [15:0]       col_inc;
  logic [NFE_W-1:0]  nfe_inc;

  logic              stk_we, stk_re, tab_we, tab_re;
  logic [7:0]        stk_wdata, stk_rdata, suf_wdata, suf_rdata;
  logic [CODE_W-1:0] pre_wdata, pre_rdata;
  logic [AW-1:0]     stk_raddr;

  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_r[AW-1:0]), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));
  gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk, .we(tab_we), .waddr(nfe_r[AW-1:0]), .wdata(pre_wdata),
    .re(tab_re), .raddr(walk_r[AW-1:0]), .rdata(pre_rdata));
  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk, .we(tab_we), .waddr(nfe_r[AW-1:0]), .wdata(suf_wdata),
    .re(tab_re), .raddr(walk_r[AW-1:0]), .rdata(suf_rdata));

  assign ms        = min_size(cfg.init_code_size);
  assign clr       = CODE_W'(12'd1 << ms);
  assign eoi       = clr + CODE_W'(1);
  assign first     = clr + CODE_W'(2);
  assign mask      = (24'd1 << cw_r) - 24'd1;
  assign code      = CODE_W'(acc_r & mask);
  assign slot_free = !o_valid_r || out_tready;
  assign stk_full  = (stk_r >= (AW+1)'(TABLE_ENTRIES));
  assign pix_inc   = pix_r + 32'd1;
  assign col_inc   = col_r + 16'd1;
  assign nfe_inc   = nfe_r + NFE_W'(1);
  assign stk_raddr = AW'(stk_r - (AW+1)'(1));
  assign pre_wdata = prev_r;
  assign suf_wdata = walk_r[7:0];

  assign out_tvalid = o_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; stk_nxt = stk_r;
    acc_nxt = acc_r; held_nxt = held_r; cw_nxt = cw_r; nfe_nxt = nfe_r;
    prev_nxt = prev_r; code_nxt = code_r; walk_nxt = walk_r; pfs_nxt = pfs_r;
    row_nxt = row_r; col_nxt = col_r; pix_nxt = pix_r; prod_nxt = prod_r;
    o_valid_nxt = o_valid_r && !out_tready;
    o_status_nxt = o_status_r; o_data_nxt = o_data_r; o_last_nxt = o_last_r;
    pop = 1'b0; stk_we = 1'b0; stk_re = 1'b0; tab_we = 1'b0; tab_re = 1'b0;
    stk_wdata = walk_r[7:0];
    unique case (state_r)
      S_IDLE: begin
        if (head.valid && slot_free) begin
          pop = 1'b1;
          o_data_nxt = '0;
          o_last_nxt = 1'b0;
          unique case (head.item.op)
            OP_START: begin
              cw_nxt = ms + 4'd1; nfe_nxt = NFE_W'(first); prev_nxt = clr;
              stk_nxt = '0; acc_nxt = '0; held_nxt = '0; pfs_nxt = '0;
              row_nxt = '0; col_nxt = '0; pix_nxt = '0; phase_nxt = PH_RUN;
              o_valid_nxt = 1'b1; o_status_nxt = ST_STARTED;
            end
            OP_PUSH: begin
              o_valid_nxt = 1'b1;
              if (held_r <= 5'd16) begin
                acc_nxt = acc_r | (24'(head.item.data_byte) << held_r);
                held_nxt = held_r + 5'd8;
                o_status_nxt = ST_TAKEN;
              end else begin
                o_status_nxt = ST_REFUSED;
              end
            end
            default: begin
              if (phase_r == PH_ERR) begin
                o_valid_nxt = 1'b1; o_status_nxt = ST_ERROR;
              end else if (pix_r >= maxpix_r) begin
                phase_nxt = PH_DONE; o_valid_nxt = 1'b1; o_status_nxt = ST_DONE;
              end else begin
                state_nxt = S_PULL;
              end
            end
          endcase
        end
      end
      S_PULL: begin
        if (stk_r != '0) begin
          stk_re = 1'b1;
          stk_nxt = stk_r - (AW+1)'(1);
          prod_nxt = {16'd0, row_r} * {15'd0, cfg.row_stride};
          state_nxt = S_PIX;
        end else if (phase_r == PH_DONE) begin
          if (slot_free) begin
            o_valid_nxt = 1'b1; o_status_nxt = ST_DONE; o_data_nxt = '0;
            o_last_nxt = 1'b0; state_nxt = S_IDLE;
          end
        end else if (held_r < {1'b0, cw_r}) begin
          if (slot_free) begin
            o_valid_nxt = 1'b1; o_status_nxt = ST_NEED; o_data_nxt = '0;
            o_last_nxt = 1'b0; state_nxt = S_IDLE;
          end
        end else begin
          acc_nxt = acc_r >> cw_r;
          held_nxt = held_r - {1'b0, cw_r};
          code_nxt = code;
          if (code == clr) begin
            cw_nxt = ms + 4'd1; nfe_nxt = NFE_W'(first); prev_nxt = clr;
          end else if (code == eoi) begin
            phase_nxt = PH_DONE;
          end else if ({1'b0, code} < nfe_r) begin
            walk_nxt = code; state_nxt = S_WALK;
          end else if ({1'b0, code} != nfe_r || prev_r == clr || stk_full) begin
            phase_nxt = PH_ERR; stk_nxt = '0; state_nxt = S_ERR;
          end else begin
            stk_we = 1'b1; stk_wdata = pfs_r; stk_nxt = stk_r + (AW+1)'(1);
            walk_nxt = prev_r; state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_r >= first) begin
          if ({1'b0, walk_r} >= NFE_W'(TABLE_ENTRIES)) begin
            phase_nxt = PH_ERR; stk_nxt = '0; state_nxt = S_ERR;
          end else begin
            tab_re = 1'b1; state_nxt = S_WDAT;
          end
        end else if (stk_full ||
                     (prev_r != clr && nfe_r >= NFE_W'(TABLE_ENTRIES))) begin
          phase_nxt = PH_ERR; stk_nxt = '0; state_nxt = S_ERR;
        end else begin
          stk_we = 1'b1; stk_nxt = stk_r + (AW+1)'(1);
          if (prev_r != clr) begin
            tab_we = 1'b1;
            nfe_nxt = nfe_inc;
            if (cw_r < 4'(MAX_CODE_BITS) && nfe_inc >= (NFE_W'(1) << cw_r))
              cw_nxt = cw_r + 4'd1;
          end
          prev_nxt = code_r; pfs_nxt = walk_r[7:0]; state_nxt = S_PULL;
        end
      end
      S_WDAT: begin
        if (stk_full) begin
          phase_nxt = PH_ERR; stk_nxt = '0; state_nxt = S_ERR;
        end else begin
          stk_we = 1'b1; stk_wdata = suf_rdata; stk_nxt = stk_r + (AW+1)'(1);
          walk_nxt = pre_rdata; state_nxt = S_WALK;
        end
      end
      S_PIX: begin
        if (slot_free) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_PIXEL;
          o_data_nxt = {prod_r + 32'(col_r), col_r, row_r, stk_rdata};
          o_last_nxt = (pix_inc == maxpix_r);
          pix_nxt = pix_inc;
          if (col_inc >= cfg.image_width) begin
            col_nxt = '0;
            row_nxt = next_row(row_r, cfg.image_height, cfg.interlace_mode);
          end else begin
            col_nxt = col_inc;
          end
          if (pix_inc >= maxpix_r) phase_nxt = PH_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        if (slot_free) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_ERROR; o_data_nxt = '0;
          o_last_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; phase_r <= PH_RUN; stk_r <= '0; acc_r <= '0;
      held_r <= '0; cw_r <= 4'd9; nfe_r <= NFE_W'(258); prev_r <= CODE_W'(256);
      pfs_r <= '0; row_r <= '0; col_r <= '0; pix_r <= '0; maxpix_r <= 32'd1;
      o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; stk_r <= stk_nxt; acc_r <= acc_nxt;
      held_r <= held_nxt; cw_r <= cw_nxt; nfe_r <= nfe_nxt; prev_r <= prev_nxt;
      pfs_r <= pfs_nxt; row_r <= row_nxt; col_r <= col_nxt; pix_r <= pix_nxt;
      maxpix_r <= {16'd0, cfg.image_width} * {16'd0, cfg.image_height};
      o_valid_r <= o_valid_nxt;
    end
    code_r <= code_nxt; walk_r <= walk_nxt; prod_r <= prod_nxt;
    o_status_r <= o_status_nxt; o_data_r <= o_data_nxt; o_last_r <= o_last_nxt;
  end
endmodule

>>> hw/rtl/gif_lzw_decoder.sv
// gif lzw decoder top level: config registers, input queue and decode back end
// depends on gld_pkg, gld_front, gld_core and gif_lzw_decoder_macros.svh
//
// in channel: tuser carries the operation (start, push byte, pull pixel),
// tdata the compressed byte. every start, push and pull beat gives exactly one
// out beat; operation code 3 is dropped and gives none. out tuser carries the
// status, tlast marks the final pixel of the image.
// a two-entry queue sits between the input and the decode engine, so input
// beats keep being taken while a result waits for the receiver.
// start and push beats pass the queue slot and then the output register.
// a pull from a filled stack passes S_PULL, which reads the stack, and S_PIX;
// a pull that decodes a new code first extracts it in S_PULL, then passes
// S_WALK and S_WDAT for every prefix chain entry and S_WALK for the literal,
// the prefix/suffix ram walk being the limit; a clear code re-enters S_PULL.
// reset brings the config registers to their defaults and the decoder to an
// empty running state; table contents are left as they are.
// while the receiver stalls the output register holds its beat and the engine
// waits; the queue fills and then in_tready drops.
module gif_lzw_decoder #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // operation
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [71:0] out_tdata,  // pixel_value, pixel_row, pixel_col, pixel_address
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import gld_pkg::*;
  `include "gif_lzw_decoder_macros.svh"

  cfg_t    cfg_r;
  q_head_t head;
  logic    pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{init_code_size: 4'd8, image_width: 16'd1, image_height: 16'd1,
                 row_stride: 17'd1, interlace_mode: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_INIT_SIZE: cfg_r.init_code_size <= cfg_wdata[3:0];
        IDX_WIDTH:     cfg_r.image_width    <= cfg_wdata[15:0];
        IDX_HEIGHT:    cfg_r.image_height   <= cfg_wdata[15:0];
        IDX_STRIDE:    cfg_r.row_stride     <= cfg_wdata;
        IDX_INTERLACE: cfg_r.interlace_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  gld_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata, .head, .pop);

  gld_core #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_core (
    .clk, .rst_n, .cfg(cfg_r), .head, .pop,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata, .out_tlast);

  `GLD_ASSERT_NOW(a_status_no_data, clk, rst_n, out_tvalid && out_tuser != ST_PIXEL, out_tdata == '0 && !out_tlast)
  `GLD_ASSERT_NOW(a_last_is_pixel, clk, rst_n, out_tvalid && out_tlast, out_tuser == ST_PIXEL)
  `GLD_ASSERT_NEXT(a_cfg_init, clk, rst_n, cfg_we && cfg_index == IDX_INIT_SIZE, cfg_r.init_code_size == $past(cfg_wdata[3:0]))
endmodule
